### src/i64div_pkg.sv
// ----------------------------------------------------------------------------
// i64div_pkg
// Types and constants shared by the 64-bit integer divider.
// ----------------------------------------------------------------------------
package i64div_pkg;

  localparam int unsigned PORT_W = 64;

  // Operation codes
  localparam logic [1:0] CMD_UQUO = 2'd0;
  localparam logic [1:0] CMD_UREM = 2'd1;
  localparam logic [1:0] CMD_SQUO = 2'd2;
  localparam logic [1:0] CMD_SREM = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [PORT_W-1:0] dividend;
    logic [PORT_W-1:0] divisor;
  } in_item_t;

  typedef struct packed {
    logic [PORT_W-1:0] result;
    logic              div_by_zero;
  } out_item_t;

  // Status of the iterative divide unit
  typedef struct packed {
    logic done;
  } core_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN,
    ST_FIX
  } state_t;

endpackage

### src/i64div_core.sv
// ----------------------------------------------------------------------------
// i64div_core
// Radix-2 restoring divide unit: one shared subtractor, one quotient bit per
// cycle.
// ----------------------------------------------------------------------------
module i64div_core #(
  parameter int unsigned W = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [W-1:0]          num,
  input  logic [W-1:0]          den,
  output logic [W-1:0]          quo,
  output logic [W-1:0]          rem,
  output i64div_pkg::core_stat_t stat
);

  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  nq_r;   // dividend bits shift out, quotient bits shift in
  logic [W-1:0]  rem_r;
  logic [W-1:0]  den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic          carry;
  logic [W-1:0]  rem_sh;
  logic [W+1:0]  diff;
  logic          take;

  always_comb begin
    carry  = rem_r[W-1];
    rem_sh = {rem_r[W-2:0], nq_r[W-1]};
    diff   = {1'b0, carry, rem_sh} - {2'b00, den_r};
    take   = ~diff[W+1];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq_r  <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      nq_r  <= {nq_r[W-2:0], take};
      rem_r <= take ? diff[W-1:0] : rem_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo       = nq_r;
  assign rem       = rem_r;
  assign stat.done = done_r;

endmodule

### src/int64_divider_signed_unsigned.sv
// ----------------------------------------------------------------------------
// int64_divider_signed_unsigned
// Signed/unsigned integer divider, quotient or remainder per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries cmd, dividend, divisor.
//   Output channel out_valid/out_stall/out_data carries result and
//   div_by_zero. Only the low DATA_WIDTH bits of the operands are used;
//   result bits above DATA_WIDTH are zero.
//   One item is in flight at a time: in_stall is high from the cycle after
//   an accept until the item's result has been loaded into the output
//   register. From accept to out_valid an item passes through the operand
//   magnitudes, the subtract-shift iterations of the shared divide unit,
//   its done handoff, and the sign fixup with the output load. No new item
//   is taken until the previous result has been loaded. A zero divisor
//   skips the divide unit and goes straight to the fixup, with quotient all
//   ones, remainder = dividend.
//   The output register lets the next item be accepted while a result waits;
//   if out_stall holds the previous result, the fixup step waits for it.
//   Reset (rst_n low, synchronous) drops out_valid and returns to idle.
// ----------------------------------------------------------------------------
module int64_divider_signed_unsigned #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  i64div_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i64div_pkg::out_item_t out_data
);

  localparam int unsigned W = DATA_WIDTH;

  i64div_pkg::state_t     state_r, state_nxt;
  i64div_pkg::core_stat_t core_stat;

  logic [1:0]   cmd_r;
  logic [W-1:0] a_r, b_r;
  logic         dz_r, neg_q_r, neg_r_r;
  logic         out_valid_r;
  i64div_pkg::out_item_t out_data_r;

  logic         want_rem, is_signed;
  logic         a_neg, b_neg;
  logic [W-1:0] mag_a, mag_b;
  logic [W-1:0] quo, rem, res;
  logic         accept, core_start, load_out, out_free;

  assign want_rem  = (cmd_r == i64div_pkg::CMD_UREM) || (cmd_r == i64div_pkg::CMD_SREM);
  assign is_signed = (cmd_r == i64div_pkg::CMD_SQUO) || (cmd_r == i64div_pkg::CMD_SREM);
  assign a_neg     = is_signed & a_r[W-1];
  assign b_neg     = is_signed & b_r[W-1];
  assign mag_a     = a_neg ? (~a_r + 1'b1) : a_r;
  assign mag_b     = b_neg ? (~b_r + 1'b1) : b_r;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign accept    = in_valid & ~in_stall;

  i64div_core #(.W(W)) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (core_start),
    .num   (mag_a),
    .den   (mag_b),
    .quo   (quo),
    .rem   (rem),
    .stat  (core_stat)
  );

  // Sign fixup and special cases
  always_comb begin
    if (dz_r) begin
      res = want_rem ? a_r : '1;
    end else if (want_rem) begin
      res = neg_r_r ? (~rem + 1'b1) : rem;
    end else begin
      res = neg_q_r ? (~quo + 1'b1) : quo;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      i64div_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = i64div_pkg::ST_PREP;
      end
      i64div_pkg::ST_PREP: begin
        state_nxt = (b_r == '0) ? i64div_pkg::ST_FIX : i64div_pkg::ST_RUN;
      end
      i64div_pkg::ST_RUN: begin
        if (core_stat.done) state_nxt = i64div_pkg::ST_FIX;
      end
      i64div_pkg::ST_FIX: begin
        if (out_free) state_nxt = i64div_pkg::ST_IDLE;
      end
      default: state_nxt = i64div_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall   = 1'b1;
    core_start = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      i64div_pkg::ST_IDLE: in_stall = 1'b0;
      i64div_pkg::ST_PREP: core_start = (b_r != '0);
      i64div_pkg::ST_RUN:  ;
      i64div_pkg::ST_FIX:  load_out = out_free;
      default:             ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= i64div_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data.cmd;
      a_r   <= in_data.dividend[W-1:0];
      b_r   <= in_data.divisor[W-1:0];
    end
    if (state_r == i64div_pkg::ST_PREP) begin
      dz_r    <= (b_r == '0);
      neg_q_r <= a_neg ^ b_neg;
      neg_r_r <= a_neg;
    end
    if (load_out) begin
      out_data_r.result      <= i64div_pkg::PORT_W'(res);
      out_data_r.div_by_zero <= dz_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/i64div_chk.sv
// ----------------------------------------------------------------------------
// i64div_chk
// Port-level checks for the integer divider, bound to the top level.
// ----------------------------------------------------------------------------
module i64div_chk #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input i64div_pkg::out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off after accept");

  // no result can appear in the cycle right after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.result >> DATA_WIDTH) == '0))
    else $error("result bits above DATA_WIDTH set");

endmodule

bind int64_divider_signed_unsigned i64div_chk #(.DATA_WIDTH(DATA_WIDTH)) u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
